>>> design/front_panel_link_controller_top_defines.svh
// ============================================================================
// Front panel link controller - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ============================================================================
`ifndef FRONT_PANEL_LINK_CONTROLLER_TOP_DEFINES_SVH
`define FRONT_PANEL_LINK_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication
`define FPLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fplc_pkg.sv
// ============================================================================
// fplc_pkg
// Types, codes and sizing constants of the front panel link controller.
// ============================================================================
package fplc_pkg;

    localparam int STACK_DEPTH = 20;
    localparam int NUM_BUTTONS = 19;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [7:0] KNOB_LO   = 8'd20;
    localparam logic [7:0] KNOB_HI   = 8'd27;
    localparam logic [7:0] PRESS_BIT = 8'h80;
    localparam logic [7:0] LOW7_MASK = 8'h7f;

    localparam logic [7:0] CODE_A_ON  = 8'd129;
    localparam logic [7:0] CODE_A_OFF = 8'd1;
    localparam logic [7:0] CODE_B_ON  = 8'd130;
    localparam logic [7:0] CODE_B_OFF = 8'd2;
    localparam logic [7:0] CODE_T_ON  = 8'd131;
    localparam logic [7:0] CODE_T_OFF = 8'd3;

    localparam logic [9:0] DEBOUNCE_RST   = 10'd100;
    localparam logic [9:0] LONG_PRESS_RST = 10'd500;
    localparam logic [9:0] HOLDOFF_RST    = 10'd100;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_TICK = 2'd1,
        REQ_LED  = 2'd2
    } req_e;

    typedef enum logic [1:0] {
        LED_A    = 2'd0,
        LED_B    = 2'd1,
        LED_TRIG = 2'd2
    } led_sel_e;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_PRESS     = 3'd1,
        EV_RELEASE   = 3'd2,
        EV_REL_SHORT = 3'd3,
        EV_REL_LONG  = 3'd4,
        EV_KNOB_L    = 3'd5,
        EV_KNOB_R    = 3'd6
    } event_kind_e;

    typedef enum logic [1:0] {
        LBL_NONE = 2'd0,
        LBL_SHOW = 2'd1,
        LBL_HIDE = 2'd2
    } label_e;

    typedef enum logic [1:0] {
        REG_RUNNING    = 2'd0,
        REG_DEBOUNCE   = 2'd1,
        REG_LONG_PRESS = 2'd2,
        REG_HOLDOFF    = 2'd3
    } reg_idx_e;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] cmd;
        logic [1:0] sel;
        logic       on;
    } item_t;

    typedef struct packed {
        logic       running;
        logic [9:0] debounce;
        logic [9:0] long_press;
        logic [9:0] holdoff;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] code;
        logic       err;
    } key_res_t;

    typedef struct packed {
        logic       p0;
        logic [7:0] code0;
        logic       p1;
        logic [7:0] code1;
    } push_req_t;

endpackage

>>> design/fplc_keys.sv
// ============================================================================
// fplc_keys
// Millisecond counter, key debounce, held-key tracking, long-press timer
// and command byte decode.
// ============================================================================
`include "front_panel_link_controller_top_defines.svh"

module fplc_keys (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  fplc_pkg::item_t     item,
    input  fplc_pkg::cfg_t      cfg,
    output logic [31:0]         ms_count,
    output fplc_pkg::key_res_t  res,
    output logic [4:0]          captured
);

    logic [31:0] ms_reg, ms_next;
    logic [31:0] lpt_reg, lpt_next;
    logic [31:0] lrt_reg, lrt_next;
    logic [4:0]  held_reg, held_next;
    logic        lt_act_reg, lt_act_next;
    logic [9:0]  lt_left_reg, lt_left_next;
    logic [4:0]  capt_reg, capt_next;

    logic [7:0]  c;
    logic [7:0]  low;
    logic [31:0] rel_diff;
    logic [31:0] prs_diff;
    logic        rel_ok;
    logic        prs_ok;
    logic [9:0]  left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg      <= '0;
            lpt_reg     <= '0;
            lrt_reg     <= '0;
            held_reg    <= '0;
            lt_act_reg  <= 1'b0;
            lt_left_reg <= '0;
            capt_reg    <= '0;
        end
        else
        begin
            ms_reg      <= ms_next;
            lpt_reg     <= lpt_next;
            lrt_reg     <= lrt_next;
            held_reg    <= held_next;
            lt_act_reg  <= lt_act_next;
            lt_left_reg <= lt_left_next;
            capt_reg    <= capt_next;
        end
    end

    always_comb
    begin
        c        = item.cmd;
        low      = item.cmd & fplc_pkg::LOW7_MASK;
        rel_diff = ms_reg - lrt_reg;
        prs_diff = ms_reg - lpt_reg;
        rel_ok   = (c >= 8'd1) && (c < 8'(fplc_pkg::NUM_BUTTONS))
                   && (rel_diff > {22'd0, cfg.debounce});
        prs_ok   = c[7] && (low >= 8'd1) && (low < 8'(fplc_pkg::NUM_BUTTONS))
                   && (prs_diff > {22'd0, cfg.debounce});
        left_dec = (lt_left_reg != '0) ? lt_left_reg - 10'd1 : lt_left_reg;

        ms_next      = ms_reg;
        lpt_next     = lpt_reg;
        lrt_next     = lrt_reg;
        held_next    = held_reg;
        lt_act_next  = lt_act_reg;
        lt_left_next = lt_left_reg;
        capt_next    = capt_reg;
        res          = '0;

        if (fire)
        begin
            case (item.req)
                fplc_pkg::REQ_CMD:
                begin
                    if (rel_ok)
                    begin
                        lrt_next = ms_reg;
                    end
                    if (prs_ok)
                    begin
                        lpt_next  = ms_reg;
                        capt_next = low[4:0];
                    end
                    if (cfg.running)
                    begin
                        if (rel_ok)
                        begin
                            res.code = c[4:0];
                            if (held_reg != '0)
                            begin
                                res.kind  = fplc_pkg::EV_REL_SHORT;
                                held_next = '0;
                            end
                            else
                            begin
                                res.kind = fplc_pkg::EV_RELEASE;
                            end
                        end
                        else if (prs_ok)
                        begin
                            res.kind     = fplc_pkg::EV_PRESS;
                            res.code     = low[4:0];
                            held_next    = low[4:0];
                            lt_act_next  = 1'b1;
                            lt_left_next = cfg.long_press;
                        end
                        else if (c >= fplc_pkg::KNOB_LO && c <= fplc_pkg::KNOB_HI)
                        begin
                            res.kind = fplc_pkg::EV_KNOB_L;
                            res.code = c[4:0];
                        end
                        else if (c >= (fplc_pkg::PRESS_BIT + fplc_pkg::KNOB_LO)
                                 && c <= (fplc_pkg::PRESS_BIT + fplc_pkg::KNOB_HI))
                        begin
                            res.kind = fplc_pkg::EV_KNOB_R;
                            res.code = low[4:0];
                        end
                        res.err = (c > fplc_pkg::KNOB_HI && c < (fplc_pkg::PRESS_BIT + 8'd1))
                                  || (c > (fplc_pkg::PRESS_BIT + fplc_pkg::KNOB_HI));
                    end
                end
                fplc_pkg::REQ_TICK:
                begin
                    ms_next = ms_reg + 32'd1;
                    if (lt_act_reg)
                    begin
                        lt_left_next = left_dec;
                        if (left_dec == '0)
                        begin
                            lt_act_next = 1'b0;
                            if (held_reg != '0)
                            begin
                                if (cfg.running)
                                begin
                                    res.kind = fplc_pkg::EV_REL_LONG;
                                    res.code = held_reg;
                                end
                                held_next = '0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ms_count = ms_reg;
    assign captured = capt_next;

    `FPLC_ASSERT_NEXT(a_long_timer_stops, fire && item.req == fplc_pkg::REQ_TICK && lt_act_reg && lt_left_reg <= 10'd1, !lt_act_reg && held_reg == '0, "long-press timer did not expire")

endmodule

>>> design/fplc_leds.sv
// ============================================================================
// fplc_leds
// LED request decode and trigger LED hold-off; builds stack push requests.
// ============================================================================
module fplc_leds (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  fplc_pkg::item_t      item,
    input  logic [31:0]          ms_count,
    input  logic [9:0]           holdoff,
    output fplc_pkg::push_req_t  push,
    output logic [1:0]           label
);

    logic        first_reg, first_next;
    logic        lit_reg, lit_next;
    logic [31:0] en_time_reg, en_time_next;
    logic [31:0] en_eff;
    logic [31:0] off_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= 1'b1;
            lit_reg     <= 1'b0;
            en_time_reg <= '0;
        end
        else
        begin
            first_reg   <= first_next;
            lit_reg     <= lit_next;
            en_time_reg <= en_time_next;
        end
    end

    always_comb
    begin
        first_next   = first_reg;
        lit_next     = lit_reg;
        en_time_next = en_time_reg;
        push         = '0;
        label        = fplc_pkg::LBL_NONE;
        en_eff       = (first_reg || item.on) ? ms_count : en_time_reg;
        off_diff     = ms_count - en_eff;

        if (fire && item.req == fplc_pkg::REQ_LED)
        begin
            case (item.sel)
                fplc_pkg::LED_A:
                begin
                    push.p0    = 1'b1;
                    push.code0 = item.on ? fplc_pkg::CODE_A_ON : fplc_pkg::CODE_A_OFF;
                end
                fplc_pkg::LED_B:
                begin
                    push.p0    = 1'b1;
                    push.code0 = item.on ? fplc_pkg::CODE_B_ON : fplc_pkg::CODE_B_OFF;
                end
                fplc_pkg::LED_TRIG:
                begin
                    en_time_next = en_eff;
                    if (first_reg)
                    begin
                        push.p0    = 1'b1;
                        push.code0 = fplc_pkg::CODE_T_OFF;
                        label      = fplc_pkg::LBL_HIDE;
                        first_next = 1'b0;
                    end
                    if (item.on != lit_reg)
                    begin
                        if (item.on)
                        begin
                            push.p1    = 1'b1;
                            push.code1 = fplc_pkg::CODE_T_ON;
                            label      = fplc_pkg::LBL_SHOW;
                            lit_next   = 1'b1;
                        end
                        else if (off_diff > {22'd0, holdoff})
                        begin
                            push.p1    = 1'b1;
                            push.code1 = fplc_pkg::CODE_T_OFF;
                            label      = fplc_pkg::LBL_HIDE;
                            lit_next   = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> design/fplc_stack.sv
// ============================================================================
// fplc_stack
// LIFO of reply codes: up to two pushes or one pop per transaction.
// The popped word is registered and held until the next pop.
// ============================================================================
`include "front_panel_link_controller_top_defines.svh"

module fplc_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop,
    input  fplc_pkg::push_req_t  push,
    output logic [7:0]           pop_word,
    output logic                 dropped
);

    localparam logic [fplc_pkg::FILL_W-1:0] DEPTH = fplc_pkg::FILL_W'(fplc_pkg::STACK_DEPTH);

    logic [7:0]                  mem [fplc_pkg::STACK_DEPTH];
    logic [fplc_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [fplc_pkg::FILL_W-1:0] fill_a;
    logic [fplc_pkg::FILL_W-1:0] fill_m1;
    logic [7:0]                  word_reg;
    logic                        full0, full1, w0, w1;

    always_comb
    begin
        full0     = fill_reg >= DEPTH;
        w0        = push.p0 && !full0;
        fill_a    = fill_reg + {{(fplc_pkg::FILL_W-1){1'b0}}, w0};
        full1     = fill_a >= DEPTH;
        w1        = push.p1 && !full1;
        dropped   = (push.p0 && full0) || (push.p1 && full1);
        fill_m1   = fill_reg - {{(fplc_pkg::FILL_W-1){1'b0}}, 1'b1};
        fill_next = fill_a + {{(fplc_pkg::FILL_W-1){1'b0}}, w1};
        if (pop && fill_reg != '0)
        begin
            fill_next = fill_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            word_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (pop)
            begin
                word_reg <= (fill_reg != '0) ? mem[fill_m1[fplc_pkg::PTR_W-1:0]] : 8'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (w0)
        begin
            mem[fill_reg[fplc_pkg::PTR_W-1:0]] <= push.code0;
        end
        if (w1)
        begin
            mem[fill_a[fplc_pkg::PTR_W-1:0]] <= push.code1;
        end
    end

    assign pop_word = word_reg;

    `FPLC_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= DEPTH, "stack fill past depth")
    `FPLC_ASSERT_NEXT(a_empty_pop, pop && fill_reg == '0 && !push.p0 && !push.p1, fill_reg == '0, "pop of empty stack moved fill")

endmodule

>>> design/front_panel_link_controller_top.sv
// ============================================================================
// front_panel_link_controller_top
// Front panel link controller: key/knob decode, long press, LED reply stack.
// ============================================================================
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------------
//  in        | in_valid / in_stall       | req_type command_byte led_select led_on
//  out       | out_valid / out_stall     | event_kind .. captured_button
//  config    | APB psel/penable/pwrite   | paddr pwdata prdata pready
//
//  One transaction per cycle unless out_stall holds the result register; input register, then result register.
//  All per-transaction state updates as the item moves from input register to result register.
//  rst_n clears control state, config to defaults; stack contents are not cleared.
//  out_stall holds the result register; in_stall rises only when both registers are full.
// ============================================================================
`include "front_panel_link_controller_top_defines.svh"

module front_panel_link_controller_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  command_byte,
    input  logic [1:0]  led_select,
    input  logic        led_on,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [4:0]  event_code,
    output logic        link_error,
    output logic        reply_valid,
    output logic [7:0]  reply_word,
    output logic        push_dropped,
    output logic [1:0]  trig_label,
    output logic [4:0]  captured_button,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fplc_pkg::cfg_t      cfg_reg;
    fplc_pkg::item_t     item_reg;
    logic                in_full_reg;
    logic                out_valid_reg;
    logic                adv;
    logic                in_take;

    logic [31:0]         ms_count;
    fplc_pkg::key_res_t  key_res;
    logic [4:0]          captured;
    fplc_pkg::push_req_t push;
    logic [1:0]          label;
    logic [7:0]          pop_word;
    logic                dropped;
    logic                pop;

    logic [2:0]          kind_reg;
    logic [4:0]          code_reg;
    logic                err_reg;
    logic                rvalid_reg;
    logic                dropped_reg;
    logic [1:0]          label_reg;
    logic [4:0]          capt_reg;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.running    <= 1'b1;
            cfg_reg.debounce   <= fplc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press <= fplc_pkg::LONG_PRESS_RST;
            cfg_reg.holdoff    <= fplc_pkg::HOLDOFF_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                fplc_pkg::REG_RUNNING:    cfg_reg.running    <= pwdata[0];
                fplc_pkg::REG_DEBOUNCE:   cfg_reg.debounce   <= pwdata[9:0];
                fplc_pkg::REG_LONG_PRESS: cfg_reg.long_press <= pwdata[9:0];
                fplc_pkg::REG_HOLDOFF:    cfg_reg.holdoff    <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fplc_pkg::REG_RUNNING:    prdata = {31'd0, cfg_reg.running};
            fplc_pkg::REG_DEBOUNCE:   prdata = {22'd0, cfg_reg.debounce};
            fplc_pkg::REG_LONG_PRESS: prdata = {22'd0, cfg_reg.long_press};
            fplc_pkg::REG_HOLDOFF:    prdata = {22'd0, cfg_reg.holdoff};
            default:                  prdata = '0;
        endcase
    end

    // transaction flow
    assign adv      = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_full_reg <= 1'b1;
            end
            else if (adv)
            begin
                in_full_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req <= req_type;
            item_reg.cmd <= command_byte;
            item_reg.sel <= led_select;
            item_reg.on  <= led_on;
        end
    end

    assign pop = adv && item_reg.req == fplc_pkg::REQ_CMD;

    fplc_keys u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (adv),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .ms_count (ms_count),
        .res      (key_res),
        .captured (captured)
    );

    fplc_leds u_leds (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (adv),
        .item     (item_reg),
        .ms_count (ms_count),
        .holdoff  (cfg_reg.holdoff),
        .push     (push),
        .label    (label)
    );

    fplc_stack u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (pop),
        .push     (push),
        .pop_word (pop_word),
        .dropped  (dropped)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg    <= key_res.kind;
            code_reg    <= key_res.code;
            err_reg     <= key_res.err;
            rvalid_reg  <= pop;
            dropped_reg <= dropped;
            label_reg   <= label;
            capt_reg    <= captured;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_kind      = kind_reg;
    assign event_code      = code_reg;
    assign link_error      = err_reg;
    assign reply_valid     = rvalid_reg;
    assign reply_word      = rvalid_reg ? pop_word : 8'd0;
    assign push_dropped    = dropped_reg;
    assign trig_label      = label_reg;
    assign captured_button = capt_reg;

    `FPLC_ASSERT_NEXT(a_adv_to_out, adv, out_valid_reg, "processed transaction missing at output")

endmodule

>>> tb/front_panel_link_controller_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// front_panel_link_controller_top_tb
// Self-checking bench for the front panel link controller. A driver feeds
// panel bytes, millisecond ticks and LED requests from a queue; a monitor
// predicts each result from a shadow of the controller state and compares
// every field of every output transaction. Runs through several register
// settings with random idling and stalls on both channels.
// ============================================================================
module front_panel_link_controller_top_tb;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam logic [1:0] LED_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        fplc_pkg::event_kind_e kind;
        logic [4:0]            code;
        logic                  err;
        logic                  rvalid;
        logic [7:0]            rword;
        logic                  dropped;
        fplc_pkg::label_e      label;
        logic [4:0]            captured;
    } panel_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [7:0]  command_byte = '0;
    logic [1:0]  led_select = '0;
    logic        led_on = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_kind;
    logic [4:0]  event_code;
    logic        link_error;
    logic        reply_valid;
    logic [7:0]  reply_word;
    logic        push_dropped;
    logic [1:0]  trig_label;
    logic [4:0]  captured_button;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fplc_pkg::item_t queued_panel_items[$];
    panel_out_t      predicted_panel_out[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         item_taken = 1'b0;
    bit         link_idle = 1'b0;
    bit         calm = 1'b0;
    int         gap_left = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         hold_reqs = 0;
    int         holds_done = 0;

    // shadow of the controller
    fplc_pkg::cfg_t cfg_shadow;
    logic [31:0] ms_now;
    logic [31:0] press_ms;
    logic [31:0] release_ms;
    logic [4:0]  held_key;
    logic        long_armed;
    logic [9:0]  long_remaining;
    logic [4:0]  captured_key;
    logic [7:0]  reply_stack[fplc_pkg::STACK_DEPTH];
    int          reply_fill;
    logic        trig_first;
    logic        trig_lit;
    logic [31:0] trig_time;

    front_panel_link_controller_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .command_byte    (command_byte),
        .led_select      (led_select),
        .led_on          (led_on),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_kind      (event_kind),
        .event_code      (event_code),
        .link_error      (link_error),
        .reply_valid     (reply_valid),
        .reply_word      (reply_word),
        .push_dropped    (push_dropped),
        .trig_label      (trig_label),
        .captured_button (captured_button),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    function automatic logic push_reply(logic [7:0] code);
        if (reply_fill >= fplc_pkg::STACK_DEPTH)
            return 1'b1;
        reply_stack[reply_fill] = code;
        reply_fill++;
        return 1'b0;
    endfunction

    function automatic logic [7:0] pop_reply();
        if (reply_fill == 0)
            return 8'd0;
        reply_fill--;
        return reply_stack[reply_fill];
    endfunction

    function automatic panel_out_t decode_panel_item(fplc_pkg::item_t it);
        panel_out_t r;
        logic [4:0] rel_key;
        logic [4:0] prs_key;
        logic [7:0] c;
        logic [7:0] low;
        r = '0;
        rel_key = '0;
        prs_key = '0;
        c = it.cmd;
        low = c & fplc_pkg::LOW7_MASK;
        case (it.req)
            fplc_pkg::REQ_CMD:
            begin
                if (c >= 8'd1 && c < 8'(fplc_pkg::NUM_BUTTONS) &&
                    (ms_now - release_ms) > {22'd0, cfg_shadow.debounce})
                begin
                    rel_key = c[4:0];
                    release_ms = ms_now;
                end
                if ((c & fplc_pkg::PRESS_BIT) != 8'd0 && low >= 8'd1 &&
                    low < 8'(fplc_pkg::NUM_BUTTONS) &&
                    (ms_now - press_ms) > {22'd0, cfg_shadow.debounce})
                begin
                    prs_key = low[4:0];
                    press_ms = ms_now;
                    captured_key = prs_key;
                end
                if (cfg_shadow.running)
                begin
                    if (rel_key != '0)
                    begin
                        r.code = rel_key;
                        if (held_key != '0)
                        begin
                            r.kind = fplc_pkg::EV_REL_SHORT;
                            held_key = '0;
                        end
                        else
                        begin
                            r.kind = fplc_pkg::EV_RELEASE;
                        end
                    end
                    else if (prs_key != '0)
                    begin
                        r.kind = fplc_pkg::EV_PRESS;
                        r.code = prs_key;
                        held_key = prs_key;
                        long_armed = 1'b1;
                        long_remaining = cfg_shadow.long_press;
                    end
                    else if (c >= fplc_pkg::KNOB_LO && c <= fplc_pkg::KNOB_HI)
                    begin
                        r.kind = fplc_pkg::EV_KNOB_L;
                        r.code = c[4:0];
                    end
                    else if (c >= (fplc_pkg::PRESS_BIT | fplc_pkg::KNOB_LO) &&
                             c <= (fplc_pkg::PRESS_BIT | fplc_pkg::KNOB_HI))
                    begin
                        r.kind = fplc_pkg::EV_KNOB_R;
                        r.code = low[4:0];
                    end
                    if ((c > fplc_pkg::KNOB_HI && c < fplc_pkg::PRESS_BIT + 8'd1) ||
                        c > (fplc_pkg::PRESS_BIT | fplc_pkg::KNOB_HI))
                        r.err = 1'b1;
                end
                r.rvalid = 1'b1;
                r.rword = pop_reply();
            end
            fplc_pkg::REQ_TICK:
            begin
                ms_now = ms_now + 32'd1;
                if (long_armed)
                begin
                    if (long_remaining != '0)
                        long_remaining = long_remaining - 10'd1;
                    if (long_remaining == '0)
                    begin
                        long_armed = 1'b0;
                        if (held_key != '0)
                        begin
                            if (cfg_shadow.running)
                            begin
                                r.kind = fplc_pkg::EV_REL_LONG;
                                r.code = held_key;
                            end
                            held_key = '0;
                        end
                    end
                end
            end
            fplc_pkg::REQ_LED:
            begin
                case (it.sel)
                    fplc_pkg::LED_A:
                        r.dropped = push_reply(it.on ? fplc_pkg::CODE_A_ON : fplc_pkg::CODE_A_OFF);
                    fplc_pkg::LED_B:
                        r.dropped = push_reply(it.on ? fplc_pkg::CODE_B_ON : fplc_pkg::CODE_B_OFF);
                    fplc_pkg::LED_TRIG:
                    begin
                        if (trig_first)
                        begin
                            if (push_reply(fplc_pkg::CODE_T_OFF))
                                r.dropped = 1'b1;
                            r.label = fplc_pkg::LBL_HIDE;
                            trig_time = ms_now;
                            trig_first = 1'b0;
                        end
                        if (it.on)
                            trig_time = ms_now;
                        if (it.on != trig_lit)
                        begin
                            if (it.on)
                            begin
                                if (push_reply(fplc_pkg::CODE_T_ON))
                                    r.dropped = 1'b1;
                                r.label = fplc_pkg::LBL_SHOW;
                                trig_lit = 1'b1;
                            end
                            else if ((ms_now - trig_time) > {22'd0, cfg_shadow.holdoff})
                            begin
                                if (push_reply(fplc_pkg::CODE_T_OFF))
                                    r.dropped = 1'b1;
                                r.label = fplc_pkg::LBL_HIDE;
                                trig_lit = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        r.captured = captured_key;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        fplc_pkg::item_t cur;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (queued_panel_items.size() > 0)
            begin
                cur = queued_panel_items.pop_front();
                req_type <= cur.req;
                command_byte <= cur.cmd;
                led_select <= cur.sel;
                led_on <= cur.on;
                in_valid <= 1'b1;
                gap_left = pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_done != hold_reqs)
        begin
            holds_done++;
            hold_left = 59;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        panel_out_t      want;
        fplc_pkg::item_t got_item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_panel_out.size() == 0)
                begin
                    $error("result transaction with none pending");
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_panel_out.pop_front();
                    check_field("event_kind", 8'(want.kind), 8'(event_kind));
                    check_field("event_code", 8'(want.code), 8'(event_code));
                    check_field("link_error", 8'(want.err), 8'(link_error));
                    check_field("reply_valid", 8'(want.rvalid), 8'(reply_valid));
                    check_field("reply_word", want.rword, reply_word);
                    check_field("push_dropped", 8'(want.dropped), 8'(push_dropped));
                    check_field("trig_label", 8'(want.label), 8'(trig_label));
                    check_field("captured_button", 8'(want.captured), 8'(captured_button));
                end
            end
            item_taken = in_valid && !in_stall;
            if (item_taken)
            begin
                got_item.req = req_type;
                got_item.cmd = command_byte;
                got_item.sel = led_select;
                got_item.on = led_on;
                predicted_panel_out.push_back(decode_panel_item(got_item));
            end
        end
        else
        begin
            item_taken = 1'b0;
        end
        link_idle = queued_panel_items.size() == 0 && !in_valid &&
                    predicted_panel_out.size() == 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] rq, logic [7:0] c, logic [1:0] s, logic o);
        fplc_pkg::item_t it;
        it.req = rq;
        it.cmd = c;
        it.sel = s;
        it.on = o;
        queued_panel_items.push_back(it);
    endtask

    task automatic add_cmd(logic [7:0] c);
        add_item(fplc_pkg::REQ_CMD, c, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            add_item(fplc_pkg::REQ_TICK, 8'($urandom_range(0, 255)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic add_led(logic [1:0] s, logic o);
        add_item(fplc_pkg::REQ_LED, 8'($urandom_range(0, 255)), s, o);
    endtask

    task automatic add_random_traffic(int n);
        int base;
        int pick;
        int key;
        int lim;
        int len;
        base = queued_panel_items.size();
        while (queued_panel_items.size() - base < n)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 35)
            begin
                key = int'($urandom_range(1, fplc_pkg::NUM_BUTTONS - 1));
                if (cfg_shadow.debounce < 10'd8 && $urandom_range(0, 4) != 0)
                    add_ticks(int'(cfg_shadow.debounce) + 1);
                else
                    add_ticks(int'($urandom_range(0, 2)));
                if ($urandom_range(0, 9) == 0)
                    add_cmd(8'(key));
                else
                    add_cmd(fplc_pkg::PRESS_BIT | 8'(key));
                lim = (int'(cfg_shadow.long_press) + 2 > 12) ? 12 :
                      int'(cfg_shadow.long_press) + 2;
                add_ticks(int'($urandom_range(0, lim)));
                if ($urandom_range(0, 9) == 0)
                    add_cmd(8'($urandom_range(1, fplc_pkg::NUM_BUTTONS - 1)));
                else
                    add_cmd(8'(key));
            end
            else if (pick < 45)
            begin
                len = int'($urandom_range(1, 4));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 1) != 0)
                        add_cmd(8'($urandom_range(fplc_pkg::KNOB_LO, fplc_pkg::KNOB_HI)));
                    else
                        add_cmd(fplc_pkg::PRESS_BIT |
                                8'($urandom_range(fplc_pkg::KNOB_LO, fplc_pkg::KNOB_HI)));
                end
            end
            else if (pick < 65)
            begin
                len = ($urandom_range(0, 6) == 0) ? int'($urandom_range(20, 26)) :
                                                    int'($urandom_range(1, 5));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_led(LED_NONE, 1'($urandom_range(0, 1)));
                    else
                        add_led(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 75)
            begin
                lim = (int'(cfg_shadow.holdoff) + 2 > 10) ? 10 : int'(cfg_shadow.holdoff) + 2;
                add_led(fplc_pkg::LED_TRIG, 1'b1);
                add_ticks(int'($urandom_range(0, lim)));
                add_led(fplc_pkg::LED_TRIG, 1'b0);
                if ($urandom_range(0, 9) < 3)
                    add_led(fplc_pkg::LED_TRIG, 1'($urandom_range(0, 1)));
            end
            else if (pick < 85)
            begin
                len = int'($urandom_range(1, 8));
                for (int i = 0; i < len; i++)
                    add_cmd(8'($urandom_range(0, 255)));
            end
            else
            begin
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic write_reg(fplc_pkg::reg_idx_e idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fplc_pkg::REG_RUNNING:    cfg_shadow.running = val[0];
            fplc_pkg::REG_DEBOUNCE:   cfg_shadow.debounce = val[9:0];
            fplc_pkg::REG_LONG_PRESS: cfg_shadow.long_press = val[9:0];
            fplc_pkg::REG_HOLDOFF:    cfg_shadow.holdoff = val[9:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_for_drain();
        @(posedge clk);
        do
            @(negedge clk);
        while (!link_idle);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(logic run, logic [9:0] deb, logic [9:0] lp, logic [9:0] ho,
                             int n, bit quiet, bit squeeze);
        write_reg(fplc_pkg::REG_RUNNING, 32'(run));
        write_reg(fplc_pkg::REG_DEBOUNCE, 32'(deb));
        write_reg(fplc_pkg::REG_LONG_PRESS, 32'(lp));
        write_reg(fplc_pkg::REG_HOLDOFF, 32'(ho));
        @(posedge clk);
        calm = quiet;
        add_random_traffic(n);
        if (squeeze)
            hold_reqs++;
        wait_for_drain();
    endtask

    initial
    begin
        cfg_shadow.running = 1'b1;
        cfg_shadow.debounce = fplc_pkg::DEBOUNCE_RST;
        cfg_shadow.long_press = fplc_pkg::LONG_PRESS_RST;
        cfg_shadow.holdoff = fplc_pkg::HOLDOFF_RST;
        ms_now = '0;
        press_ms = '0;
        release_ms = '0;
        held_key = '0;
        long_armed = 1'b0;
        long_remaining = '0;
        captured_key = '0;
        reply_fill = 0;
        trig_first = 1'b1;
        trig_lit = 1'b0;
        trig_time = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        run_phase(1'b1, 10'd0, 10'd3, 10'd2, 0, 1'b0, 1'b0);
        @(posedge clk);
        add_led(fplc_pkg::LED_TRIG, 1'b1);
        add_led(fplc_pkg::LED_A, 1'b1);
        add_led(fplc_pkg::LED_B, 1'b0);
        add_led(LED_NONE, 1'b1);
        add_item(REQ_NONE, 8'hff, LED_NONE, 1'b1);
        add_cmd(8'd0);
        add_ticks(1);
        add_cmd(fplc_pkg::PRESS_BIT | 8'd5);
        add_cmd(8'd5);
        add_cmd(8'd5);
        add_cmd(fplc_pkg::KNOB_LO);
        add_cmd(fplc_pkg::PRESS_BIT | fplc_pkg::KNOB_HI);
        add_cmd(8'd28);
        add_cmd(fplc_pkg::PRESS_BIT);
        add_cmd(8'hff);
        add_cmd(8'd19);
        add_cmd(fplc_pkg::PRESS_BIT | 8'd19);
        add_ticks(1);
        add_cmd(fplc_pkg::PRESS_BIT | 8'd18);
        add_ticks(3);
        add_cmd(8'd18);
        add_ticks(1);
        add_cmd(8'd1);
        add_led(fplc_pkg::LED_TRIG, 1'b0);
        wait_for_drain();

        run_phase(1'b1, 10'd2, 10'd5, 10'd3, 350, 1'b0, 1'b1);
        run_phase(1'b0, 10'd0, 10'd1, 10'd0, 200, 1'b0, 1'b0);
        run_phase(1'b1, 10'd0, 10'd1023, 10'd1023, 200, 1'b1, 1'b0);
        run_phase(1'b1, 10'd1023, 10'd1, 10'd5, 150, 1'b0, 1'b0);
        run_phase(1'b1, 10'd1, 10'd2, 10'd1, 250, 1'b0, 1'b1);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
